// ===== rtl/rmkc_pkg.sv =====
// Package: widths, table size, controller/datapath command and status types.
package rmkc_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W         = 37;
  localparam int COUNT_BITS    = 16;
  localparam int TIE_W         = 11;

  localparam logic [KEY_W-1:0]      KEY_RESET = 37'd99999999999;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TIE_W-1:0]      TIE_MAX   = {TIE_W{1'b1}};
  localparam logic [USED_W-1:0]     USED_MAX  = USED_W'(TABLE_ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_HIT  = 6'b001000,
    S_NEW  = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load_key;
    logic rd_en;
    logic idx_inc;
    logic wr_hit;
    logic wr_new;
    logic set_full;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic match;
    logic sat;
    logic full;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/rmkc_if.sv =====
// Handshake channel interfaces for key beats and result beats.
interface rmkc_in_if;
  import rmkc_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface rmkc_out_if;
  import rmkc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KEY_W-1:0]      mode_key;
  logic [COUNT_BITS-1:0] mode_count;
  logic [TIE_W-1:0]      tie_count;
  logic                  table_full;
  modport source (output valid, output mode_key, output mode_count, output tie_count,
                  output table_full, input ready);
  modport sink   (input valid, input mode_key, input mode_count, input tie_count,
                  input table_full, output ready);
endinterface

// ===== rtl/running_mode_key_counter.sv =====
// Top level: streaming most-frequent-key tracker.
// One result beat per key beat. Each key is looked up by a linear scan of the
// filled entries of a 1024-entry table held in memory with one write port
// and one registered read port; each probed entry is first read into a
// register (S_RD) and then compared (S_CMP). A found key goes on through
// S_HIT, a new key through S_NEW, then both wait in S_RES until the output
// register is free, so a sink that holds off stalls the block there.
// A new key is appended with count one; a known key's count goes up by one
// and sticks at 65535. When all 1024 entries are used, a further new key is
// dropped and its result beat shows table_full = 1. Each result reports the
// current mode (smallest key among those with the highest count), its count,
// and how many keys share that count (capped at 2047). After reset the mode
// reads key 99999999999, count 0, tie 1. No clearing pass is needed: a fill
// count marks the valid entries. The block handles one key at a time; a new
// key beat is taken once the previous result is registered for output, so it
// may be scanned while that result still waits for the sink.
module running_mode_key_counter
  import rmkc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rmkc_in_if.sink    in_ch,
  rmkc_out_if.source out_ch
);

  dp_cmd_t cmd;   // controller -> datapath
  dp_sts_t sts;   // datapath -> controller

  rmkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmkc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_key         (in_ch.key),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_mode_key   (out_ch.mode_key),
    .out_mode_count (out_ch.mode_count),
    .out_tie_count  (out_ch.tie_count),
    .out_table_full (out_ch.table_full)
  );

endmodule

// ===== rtl/rmkc_ctrl.sv =====
// Controller: sequences the table scan, update and result emission.
module rmkc_ctrl
  import rmkc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        if (sts.scan_done) begin
          state_nxt = S_NEW;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          state_nxt = S_HIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_HIT: begin
        // saturated count: leave table and mode untouched
        cmd.wr_hit = !sts.sat;
        state_nxt  = S_RES;
      end
      S_NEW: begin
        cmd.set_full = sts.full;
        cmd.wr_new   = !sts.full;
        state_nxt    = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/rmkc_dp.sv =====
// Datapath: entry memory, scan pointer, mode tracking and output register.
module rmkc_dp
  import rmkc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [KEY_W-1:0]      in_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_W-1:0]      out_mode_key,
  output logic [COUNT_BITS-1:0] out_mode_count,
  output logic [TIE_W-1:0]      out_tie_count,
  output logic                  out_table_full
);

  localparam int ENT_W = KEY_W + COUNT_BITS;

  logic [ENT_W-1:0]      mem [TABLE_ENTRIES];
  logic [ENT_W-1:0]      rd_r;
  logic [KEY_W-1:0]      key_r;
  logic [USED_W-1:0]     idx_r, used_r;
  logic [KEY_W-1:0]      best_key_r;
  logic [COUNT_BITS-1:0] best_count_r;
  logic [TIE_W-1:0]      tied_r;
  logic                  full_r;
  logic                  out_valid_r;
  logic [KEY_W-1:0]      o_key_r;
  logic [COUNT_BITS-1:0] o_count_r;
  logic [TIE_W-1:0]      o_tie_r;
  logic                  o_full_r;

  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] cnt;
  logic [IDX_W-1:0]      wr_addr;
  logic                  upd;

  assign rd_key  = rd_r[ENT_W-1:COUNT_BITS];
  assign rd_cnt  = rd_r[COUNT_BITS-1:0];
  assign cnt     = cmd.wr_hit ? rd_cnt + COUNT_BITS'(1) : COUNT_BITS'(1);
  assign wr_addr = cmd.wr_hit ? idx_r[IDX_W-1:0] : used_r[IDX_W-1:0];
  assign upd     = cmd.wr_hit | cmd.wr_new;

  assign sts.scan_done = (idx_r == used_r);
  assign sts.match     = (rd_key == key_r);
  assign sts.sat       = (rd_cnt == COUNT_MAX);
  assign sts.full      = (used_r == USED_MAX);
  assign sts.out_free  = !out_valid_r || out_ready;

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (upd) begin
      mem[wr_addr] <= {key_r, cnt};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= in_key;
    end
    if (cmd.emit) begin
      o_key_r   <= best_key_r;
      o_count_r <= best_count_r;
      o_tie_r   <= tied_r;
      o_full_r  <= full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      used_r       <= '0;
      best_key_r   <= KEY_RESET;
      best_count_r <= '0;
      tied_r       <= TIE_W'(1);
      full_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load_key) begin
        idx_r  <= '0;
        full_r <= 1'b0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + USED_W'(1);
      end
      if (cmd.set_full) begin
        full_r <= 1'b1;
      end
      if (cmd.wr_new) begin
        used_r <= used_r + USED_W'(1);
      end
      if (upd) begin
        if (cnt > best_count_r) begin
          best_key_r   <= key_r;
          best_count_r <= cnt;
          tied_r       <= TIE_W'(1);
        end else if (cnt == best_count_r) begin
          if (tied_r != TIE_MAX) begin
            tied_r <= tied_r + TIE_W'(1);
          end
          if (key_r < best_key_r) begin
            best_key_r <= key_r;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mode_key   = o_key_r;
  assign out_mode_count = o_count_r;
  assign out_tie_count  = o_tie_r;
  assign out_table_full = o_full_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_MAX) else $error("entry count overflow");
  a_tied_nz: assert property (@(posedge clk) disable iff (!rst_n)
    tied_r != '0) else $error("tie count zero");
  a_empty_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r == '0) |-> (best_count_r == '0)) else $error("mode without entries");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= used_r) else $error("scan past filled entries");
`endif

endmodule
